/* hdl/sprite_bounding_box_finder_core_defines.svh */
// ---------------------------------------------------------------------------
// sprite bounding box finder assertion macros
// shared assertion forms for the port checker
// ---------------------------------------------------------------------------
`ifndef SPRITE_BOUNDING_BOX_FINDER_CORE_DEFINES_SVH
`define SPRITE_BOUNDING_BOX_FINDER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SBBF_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SBBF_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* hdl/sbbf_pkg.sv */
// ---------------------------------------------------------------------------
// sbbf_pkg
// shared constants and controller/datapath interface types
// ---------------------------------------------------------------------------
`default_nettype none

package sbbf_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;
  localparam int CFG_RESET      = 128;
  localparam int RESULT_LIMIT   = 64;
  localparam int CNT_W          = $clog2(RESULT_LIMIT);

  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int ALPHA_W     = 8;
  localparam int OUT_X_W     = 7;
  localparam int OUT_Y_W     = 7;
  localparam int OUT_SIZE_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // commands from the controller
  typedef struct packed {
    logic pix_accept;
    logic scan_init;
    logic x_inc;
    logic band_start;
    logic band_end;
    logic xs_inc;
    logic row_next;
    logic row_hit;
    logic band_done;
    logic finish;
  } sbbf_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic pix_last;
    logic x_end;
    logic col_bit;
    logic map_bit;
    logic xs_last;
    logic y_last;
    logic found;
    logic count_last;
  } sbbf_sts_t;

endpackage

`default_nettype wire

/* hdl/sbbf_ctrl.sv */
// ---------------------------------------------------------------------------
// sbbf_ctrl
// state machine: pixel load, column band walk, map row probing, emission
// ---------------------------------------------------------------------------
`default_nettype none

module sbbf_ctrl import sbbf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire sbbf_sts_t sts,
  output sbbf_cmd_t      cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SEEK     = 4'd1;
  localparam logic [3:0] ST_SEEK_CHK = 4'd2;
  localparam logic [3:0] ST_EXT      = 4'd3;
  localparam logic [3:0] ST_EXT_CHK  = 4'd4;
  localparam logic [3:0] ST_MAP_RD   = 4'd5;
  localparam logic [3:0] ST_MAP_CHK  = 4'd6;
  localparam logic [3:0] ST_DONE     = 4'd7;
  localparam logic [3:0] ST_FINISH   = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.pix_accept = 1'b1;
          if (sts.pix_last) begin
            cmd.scan_init = 1'b1;
            state_nxt     = ST_SEEK;
          end
        end
      end
      ST_SEEK: begin
        state_nxt = sts.x_end ? ST_FINISH : ST_SEEK_CHK;
      end
      ST_SEEK_CHK: begin
        cmd.x_inc = 1'b1;
        if (sts.col_bit) begin
          cmd.band_start = 1'b1;
          state_nxt      = ST_EXT;
        end else begin
          state_nxt = ST_SEEK;
        end
      end
      ST_EXT: begin
        if (sts.x_end) begin
          cmd.band_end = 1'b1;
          state_nxt    = ST_MAP_RD;
        end else begin
          state_nxt = ST_EXT_CHK;
        end
      end
      ST_EXT_CHK: begin
        if (sts.col_bit) begin
          cmd.x_inc = 1'b1;
          state_nxt = ST_EXT;
        end else begin
          cmd.band_end = 1'b1;
          state_nxt    = ST_MAP_RD;
        end
      end
      ST_MAP_RD: begin
        state_nxt = ST_MAP_CHK;
      end
      ST_MAP_CHK: begin
        if (sts.map_bit) begin
          cmd.row_hit = 1'b1;
          if (sts.y_last) begin
            state_nxt = ST_DONE;
          end else begin
            cmd.row_next = 1'b1;
            state_nxt    = ST_MAP_RD;
          end
        end else if (!sts.xs_last) begin
          cmd.xs_inc = 1'b1;
          state_nxt  = ST_MAP_RD;
        end else if (sts.found || sts.y_last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.row_next = 1'b1;
          state_nxt    = ST_MAP_RD;
        end
      end
      ST_DONE: begin
        cmd.band_done = 1'b1;
        state_nxt     = sts.count_last ? ST_FINISH : ST_SEEK;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/sbbf_dp.sv */
// ---------------------------------------------------------------------------
// sbbf_dp
// frame registers, pixel position, column and map memories, scan counters
// ---------------------------------------------------------------------------
`default_nettype none

module sbbf_dp import sbbf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [ALPHA_W-1:0]     in_alpha,
  input  wire sbbf_cmd_t              cmd,
  output sbbf_sts_t                   sts,
  output logic                        out_valid,
  output logic [OUT_X_W-1:0]          out_rect_x,
  output logic [OUT_Y_W-1:0]          out_rect_y,
  output logic [OUT_SIZE_W-1:0]       out_rect_width,
  output logic [OUT_SIZE_W-1:0]       out_rect_height,
  output logic                        out_last_rect,
  output logic                        out_no_sprite
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int RW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int HW        = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP      = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
  localparam int HCMP      = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;
  localparam int MAP_DEPTH = 1 << (RW + CW);
  localparam int W_RST     = (MAX_WIDTH < CFG_RESET) ? MAX_WIDTH : CFG_RESET;
  localparam int H_RST     = (MAX_HEIGHT < CFG_RESET) ? MAX_HEIGHT : CFG_RESET;

  // effective frame size, clamped when written
  logic [WW-1:0]   w_r;
  logic [HW-1:0]   h_r;
  logic [WCMP-1:0] cfg_w_ext;
  logic [HCMP-1:0] cfg_h_ext;
  logic [WW-1:0]   w_clamp;
  logic [HW-1:0]   h_clamp;

  assign cfg_w_ext = WCMP'(cfg_wdata);
  assign cfg_h_ext = HCMP'(cfg_wdata);

  always_comb begin
    if (cfg_w_ext == '0) begin
      w_clamp = WW'(1);
    end else if (cfg_w_ext > WCMP'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(cfg_w_ext);
    end
    if (cfg_h_ext == '0) begin
      h_clamp = HW'(1);
    end else if (cfg_h_ext > HCMP'(MAX_HEIGHT)) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(cfg_h_ext);
    end
  end

  // pixel position
  logic [CW-1:0] pcol_r;
  logic [RW-1:0] prow_r;
  logic          pix_bit;
  logic          col_last;
  logic          row_last;

  assign pix_bit  = (in_alpha != '0);
  assign col_last = (WW'(pcol_r) == w_r - WW'(1));
  assign row_last = (HW'(prow_r) == h_r - HW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= WW'(W_RST);
      h_r    <= HW'(H_RST);
      pcol_r <= '0;
      prow_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  w_r <= w_clamp;
        REG_FRAME_HEIGHT: h_r <= h_clamp;
        default: ;
      endcase
      pcol_r <= '0;
      prow_r <= '0;
    end else if (cmd.pix_accept) begin
      if (col_last) begin
        pcol_r <= '0;
        prow_r <= row_last ? '0 : prow_r + RW'(1);
      end else begin
        pcol_r <= pcol_r + CW'(1);
      end
    end
  end

  // scan registers
  logic [WW-1:0]    x_r;
  logic [CW-1:0]    x0_r;
  logic [WW-1:0]    x1_r;
  logic [CW-1:0]    xs_r;
  logic [RW-1:0]    y_r;
  logic [RW-1:0]    y0_r;
  logic [HW-1:0]    run_r;
  logic             found_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pend_v_r;
  logic [CW-1:0]    pend_x_r;
  logic [RW-1:0]    pend_y_r;
  logic [WW-1:0]    pend_w_r;
  logic [HW-1:0]    pend_h_r;

  // column flags: row 0 overwrites, later rows only set
  logic col_mem [MAX_WIDTH];
  logic col_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.pix_accept && (prow_r == '0 || pix_bit)) begin
      col_mem[pcol_r] <= pix_bit;
    end
    col_rd_r <= col_mem[x_r[CW-1:0]];
  end

  // occupancy map, one bit per pixel
  logic map_mem [MAP_DEPTH];
  logic map_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.pix_accept) begin
      map_mem[{prow_r, pcol_r}] <= pix_bit;
    end
    map_rd_r <= map_mem[{y_r, xs_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= '0;
      found_r  <= 1'b0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      if (cmd.scan_init) begin
        x_r      <= '0;
        cnt_r    <= '0;
        pend_v_r <= 1'b0;
      end else if (cmd.x_inc) begin
        x_r <= x_r + WW'(1);
      end
      if (cmd.band_start) begin
        x0_r <= x_r[CW-1:0];
      end
      if (cmd.band_end) begin
        x1_r    <= x_r;
        xs_r    <= x0_r;
        y_r     <= '0;
        y0_r    <= '0;
        run_r   <= '0;
        found_r <= 1'b0;
      end else begin
        if (cmd.xs_inc) begin
          xs_r <= xs_r + CW'(1);
        end
        if (cmd.row_hit) begin
          run_r   <= run_r + HW'(1);
          found_r <= 1'b1;
          if (!found_r) begin
            y0_r <= y_r;
          end
        end
        if (cmd.row_next) begin
          y_r  <= y_r + RW'(1);
          xs_r <= x0_r;
        end
      end
      if (cmd.band_done) begin
        pend_v_r <= 1'b1;
        pend_x_r <= x0_r;
        pend_y_r <= y0_r;
        pend_w_r <= x1_r - WW'(x0_r);
        pend_h_r <= run_r;
        cnt_r    <= cnt_r + CNT_W'(1);
      end
      if (cmd.finish) begin
        pend_v_r <= 1'b0;
        cnt_r    <= '0;
      end
    end
  end

  assign sts.pix_last   = col_last & row_last;
  assign sts.x_end      = (x_r == w_r);
  assign sts.col_bit    = col_rd_r;
  assign sts.map_bit    = map_rd_r;
  assign sts.xs_last    = (WW'(xs_r) + WW'(1) == x1_r);
  assign sts.y_last     = (HW'(y_r) + HW'(1) == h_r);
  assign sts.found      = found_r;
  assign sts.count_last = (cnt_r == CNT_W'(RESULT_LIMIT - 1));

  // result register: previous band on a new band, final one on finish
  logic                  out_valid_r;
  logic [OUT_X_W-1:0]    out_x_r;
  logic [OUT_Y_W-1:0]    out_y_r;
  logic [OUT_SIZE_W-1:0] out_w_r;
  logic [OUT_SIZE_W-1:0] out_h_r;
  logic                  out_last_r;
  logic                  out_none_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.band_done && pend_v_r) || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && !pend_v_r) begin
      out_x_r    <= '0;
      out_y_r    <= '0;
      out_w_r    <= '0;
      out_h_r    <= '0;
      out_last_r <= 1'b1;
      out_none_r <= 1'b1;
    end else if (cmd.finish || cmd.band_done) begin
      out_x_r    <= OUT_X_W'(pend_x_r);
      out_y_r    <= OUT_Y_W'(pend_y_r);
      out_w_r    <= OUT_SIZE_W'(pend_w_r);
      out_h_r    <= OUT_SIZE_W'(pend_h_r);
      out_last_r <= cmd.finish;
      out_none_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rect_x      = out_x_r;
  assign out_rect_y      = out_y_r;
  assign out_rect_width  = out_w_r;
  assign out_rect_height = out_h_r;
  assign out_last_rect   = out_last_r;
  assign out_no_sprite   = out_none_r;

endmodule

`default_nettype wire

/* hdl/sprite_bounding_box_finder_core.sv */
// ---------------------------------------------------------------------------
// sprite_bounding_box_finder_core
// finds one rectangle per band of occupied columns in a frame of alpha bytes
// ---------------------------------------------------------------------------
// Pixels enter in raster order, one per cycle while busy is low: a pixel is
// taken at every clock edge with start high and busy low. The last pixel of
// the frame raises busy and starts the scan, during which no pixel is taken.
// The scan walks the column flags and, for each band of occupied columns,
// probes the occupancy map one bit at a time through its single registered
// read port. Results appear on out_valid for exactly one cycle each with no
// way to hold them off; a band is shown once the next band has been measured
// (or the scan ends), so out_last_rect is always set on the final result. An
// empty frame gives one result with out_no_sprite and out_last_rect set and
// zero geometry.
// Configuration writes are taken at any edge with cfg_we high and restart
// the frame; write them only while busy is low. No clearing pass is needed
// after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module sprite_bounding_box_finder_core import sbbf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  // pixel input
  input  wire logic                   start,
  input  wire logic [ALPHA_W-1:0]     in_alpha,
  output logic                        busy,
  // result output
  output logic                        out_valid,
  output logic [OUT_X_W-1:0]          out_rect_x,
  output logic [OUT_Y_W-1:0]          out_rect_y,
  output logic [OUT_SIZE_W-1:0]       out_rect_width,
  output logic [OUT_SIZE_W-1:0]       out_rect_height,
  output logic                        out_last_rect,
  output logic                        out_no_sprite
);

  sbbf_cmd_t cmd;
  sbbf_sts_t sts;

  // sequencing: load, band walk, row probing, emission
  sbbf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // storage, counters and the result register
  sbbf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_alpha        (in_alpha),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_rect_x      (out_rect_x),
    .out_rect_y      (out_rect_y),
    .out_rect_width  (out_rect_width),
    .out_rect_height (out_rect_height),
    .out_last_rect   (out_last_rect),
    .out_no_sprite   (out_no_sprite)
  );

endmodule

`default_nettype wire

/* hdl/sbbf_checker.sv */
// ---------------------------------------------------------------------------
// sbbf_checker
// port-level checks on result sequencing, bound to the core
// ---------------------------------------------------------------------------
`default_nettype none

`include "sprite_bounding_box_finder_core_defines.svh"

module sbbf_checker import sbbf_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  busy,
  input wire logic                  out_valid,
  input wire logic [OUT_SIZE_W-1:0] out_rect_width,
  input wire logic [OUT_SIZE_W-1:0] out_rect_height,
  input wire logic                  out_last_rect,
  input wire logic                  out_no_sprite
);

  // empty frame result is final and carries no geometry
  `SBBF_ASSERT_IMP(a_empty_shape, out_valid && out_no_sprite, out_last_rect && out_rect_width == '0 && out_rect_height == '0, "empty frame result malformed")

  // a real band always has columns
  `SBBF_ASSERT_IMP(a_band_width, out_valid && !out_no_sprite, out_rect_width != '0, "band of zero width")

  // intermediate results only show up while scanning
  `SBBF_ASSERT_IMP(a_mid_busy, out_valid && !out_last_rect, busy, "non-final result outside scan")

  // end of scan always delivers the final transaction
  `SBBF_ASSERT_IMP(a_end_last, $fell(busy) && $past(rst_n), out_valid && out_last_rect, "scan ended without final result")

  // nothing follows the final result
  `SBBF_ASSERT_NXT(a_after_last, out_valid && out_last_rect, !out_valid, "result after final")

endmodule

bind sprite_bounding_box_finder_core sbbf_checker u_sbbf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_rect_width  (out_rect_width),
  .out_rect_height (out_rect_height),
  .out_last_rect   (out_last_rect),
  .out_no_sprite   (out_no_sprite)
);

`default_nettype wire
